// ===== hdl/oult_pkg.sv =====
// ----------------------------------------------------------------------------
// oult_pkg
// Shared types and constants for the ordered unique list table.
// ----------------------------------------------------------------------------
package oult_pkg;

  // list geometry
  localparam int DEPTH = 256;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = 8;
  localparam int DW    = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_GET    = 2'd1,
    CMD_SET    = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_PRESENT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_GET,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

// ===== hdl/ordered_unique_list_table.sv =====
// ----------------------------------------------------------------------------
// ordered_unique_list_table
// Ordered list of 32-bit words in one synchronous memory, unique on insert.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): in_cmd selects insert, get, set or
// remove; in_index is the list position; in_value is the word to insert or
// write. Result channel (out_valid / out_stall): one transaction per input,
// carrying the word read or removed, a status code, the count after the
// operation and an empty flag.
// One transaction is worked on at a time. The memory has a single registered
// read port and one write port, and the walks over it set the time per
// transaction:
//   set    a write in the start state, as short as any out-of-range command
//   get    a read, then the word is taken in the get state
//   insert duplicate scan over every held word, stops early on a hit, then
//          the word is appended at the end if the list is not full
//   remove shift of every later word by one place
// Once the result is loaded the block goes idle and takes the next transaction.
// in_stall is high while a transaction is in flight. A finished result waits
// in its own state while the output register is still held by a stalled
// receiver. Reset empties the list (count zero); the memory is not cleared
// since positions at or beyond the count are never used.
// ----------------------------------------------------------------------------
module ordered_unique_list_table
  import oult_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_cmd,
  input  logic [IW-1:0] in_index,
  input  logic [DW-1:0] in_value,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [DW-1:0] out_value_out,
  output logic [1:0]    out_status,
  output logic [CW-1:0] out_entry_count,
  output logic          out_is_empty
);

  // word storage
  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  // control and working registers
  state_t        state_r, state_nxt;
  cmd_t          cmd_r;
  logic [IW-1:0] idx_r;
  logic [DW-1:0] val_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          pend_r, pend_nxt;
  logic          first_r, first_nxt;
  logic [DW-1:0] res_value_r, res_value_nxt;
  status_t       res_status_r, res_status_nxt;

  // output register
  logic          out_valid_r;
  logic [DW-1:0] out_value_r;
  status_t       out_status_r;
  logic [CW-1:0] out_count_r;
  logic          out_load;

  logic          in_take;
  logic          idx_in_range;
  logic [CW-1:0] ptr_minus2;

  assign in_stall     = (state_r != S_IDLE);
  assign in_take      = in_valid && (state_r == S_IDLE);
  assign idx_in_range = ({{(CW-IW){1'b0}}, idx_r} < count_r);
  assign ptr_minus2   = ptr_r - CW'(2);

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r <= cmd_t'(in_cmd);
      idx_r <= in_index;
      val_r <= in_value;
    end
  end

  // state register and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      first_r <= first_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
  end

  // next state, memory control and result
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    pend_nxt       = pend_r;
    first_nxt      = first_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    rd_addr        = ptr_r[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = ptr_minus2[AW-1:0];
    wr_data        = rd_data_r;
    out_load       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_START;
        end
      end

      S_START: begin
        res_value_nxt  = '0;
        res_status_nxt = STAT_OK;
        ptr_nxt        = '0;
        pend_nxt       = 1'b0;
        first_nxt      = 1'b1;
        rd_addr        = idx_r[AW-1:0];
        unique case (cmd_r)
          CMD_INSERT: begin
            state_nxt = S_SCAN;
          end
          CMD_GET: begin
            state_nxt = idx_in_range ? S_GET : S_DONE;
          end
          CMD_SET: begin
            if (idx_in_range) begin
              wr_en   = 1'b1;
              wr_addr = idx_r[AW-1:0];
              wr_data = val_r;
            end else begin
              res_status_nxt = STAT_RANGE;
            end
            state_nxt = S_DONE;
          end
          CMD_REMOVE: begin
            if (idx_in_range) begin
              ptr_nxt   = {{(CW-IW){1'b0}}, idx_r};
              state_nxt = S_SHIFT;
            end else begin
              res_status_nxt = STAT_RANGE;
              state_nxt      = S_DONE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end

      // duplicate scan: read at ptr, compare the word from the previous read
      S_SCAN: begin
        pend_nxt = (ptr_r < count_r);
        if (ptr_r < count_r) begin
          ptr_nxt = ptr_r + CW'(1);
        end
        if (pend_r && (rd_data_r == val_r)) begin
          res_status_nxt = STAT_PRESENT;
          pend_nxt       = 1'b0;
          state_nxt      = S_DONE;
        end else if (!pend_r && (ptr_r >= count_r)) begin
          if (count_r == CW'(DEPTH)) begin
            res_status_nxt = STAT_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = count_r[AW-1:0];
            wr_data   = val_r;
            count_nxt = count_r + CW'(1);
          end
          state_nxt = S_DONE;
        end
      end

      S_GET: begin
        res_value_nxt = rd_data_r;
        state_nxt     = S_DONE;
      end

      // remove: first word read is the result, each later one moves down
      S_SHIFT: begin
        pend_nxt = (ptr_r < count_r);
        if (ptr_r < count_r) begin
          ptr_nxt = ptr_r + CW'(1);
        end
        if (pend_r) begin
          if (first_r) begin
            res_value_nxt = rd_data_r;
            first_nxt     = 1'b0;
          end else begin
            wr_en = 1'b1;
          end
        end else if (ptr_r >= count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      // hand the result over once the output register is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
      out_count_r  <= count_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value_out   = out_value_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty    = (out_count_r == '0);

endmodule

// ===== hdl/oult_checker.sv =====
// ----------------------------------------------------------------------------
// oult_checker
// Port-level checks for the ordered unique list table, bound to the top level.
// ----------------------------------------------------------------------------
module oult_checker
  import oult_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input logic [DW-1:0] out_value_out,
  input logic [1:0]    out_status,
  input logic [CW-1:0] out_entry_count,
  input logic          out_is_empty
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // empty flag agrees with the count
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0)))
    else $error("empty flag disagrees with count");

  // count never exceeds the list depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= CW'(DEPTH)))
    else $error("count beyond depth");

  // error and duplicate results carry no word
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> (out_value_out == '0))
    else $error("word returned with non-ok status");

  // a full report only comes with a full list
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |-> (out_entry_count == CW'(DEPTH)))
    else $error("full reported below depth");

endmodule

bind ordered_unique_list_table oult_checker u_oult_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_value_out   (out_value_out),
  .out_status      (out_status),
  .out_entry_count (out_entry_count),
  .out_is_empty    (out_is_empty)
);

// ===== dv/tb_ordered_unique_list_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_unique_list_table
// Self-checking bench for the ordered unique list table.
// ----------------------------------------------------------------------------
// A short directed table covers the empty list, the word extremes, duplicate
// inserts and out-of-range set and remove. A random part follows. It fills the
// list to capacity, which also exercises the full and duplicate-in-full cases,
// then drains it and finally mixes all commands. Every result is checked field
// by field against its typed table row or a shadow copy of the list kept in
// the bench. Both channels idle in short random bursts, save near the end.
// ----------------------------------------------------------------------------
module tb_ordered_unique_list_table;
  import oult_pkg::*;

  localparam int RAND_ITEMS  = 1050;
  localparam int QUIET_ITEMS = 100;
  localparam int DRAIN_TICKS = DEPTH + 40;

  typedef struct packed {
    cmd_t          cmd;
    logic [IW-1:0] index;
    logic [DW-1:0] value;
  } list_op_t;

  typedef struct packed {
    logic [DW-1:0] value_out;
    status_t       status;
    logic [CW-1:0] entry_count;
    logic          is_empty;
  } list_rsp_t;

  typedef struct packed {
    list_op_t  op;
    logic      typed;
    list_rsp_t rsp;
  } dir_row_t;

  typedef enum int {
    PH_GROW,
    PH_SHRINK,
    PH_MIX
  } phase_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [1:0]    in_cmd;
  logic [IW-1:0] in_index;
  logic [DW-1:0] in_value;
  logic          out_valid;
  logic          out_stall;
  logic [DW-1:0] out_value_out;
  logic [1:0]    out_status;
  logic [CW-1:0] out_entry_count;
  logic          out_is_empty;

  // shadow copy of the list
  logic [DW-1:0] shadow_words [DEPTH];
  int            shadow_count;

  list_rsp_t     pending_rsps [$];
  int            mismatches = 0;
  bit            idle_on;

  ordered_unique_list_table i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_index        (in_index),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value_out   (out_value_out),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard limit on run time
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // apply one command to the shadow list and return its result
  function automatic list_rsp_t apply_list_op(list_op_t op);
    list_rsp_t rsp;
    bit        hit;
    int        idx;
    rsp.value_out = '0;
    rsp.status    = STAT_OK;
    idx           = int'(op.index);
    case (op.cmd)
      CMD_INSERT: begin
        hit = 1'b0;
        for (int i = 0; i < shadow_count; i++)
          if (shadow_words[i] == op.value) hit = 1'b1;
        if (hit) begin
          rsp.status = STAT_PRESENT;
        end else if (shadow_count >= DEPTH) begin
          rsp.status = STAT_FULL;
        end else begin
          shadow_words[shadow_count] = op.value;
          shadow_count++;
        end
      end
      CMD_GET: begin
        if (idx < shadow_count) rsp.value_out = shadow_words[idx];
      end
      CMD_SET: begin
        if (idx < shadow_count) shadow_words[idx] = op.value;
        else rsp.status = STAT_RANGE;
      end
      default: begin
        if (idx < shadow_count) begin
          rsp.value_out = shadow_words[idx];
          // close the gap, later words keep their order
          for (int i = idx; i + 1 < shadow_count; i++)
            shadow_words[i] = shadow_words[i + 1];
          shadow_count--;
        end else begin
          rsp.status = STAT_RANGE;
        end
      end
    endcase
    rsp.entry_count = CW'(shadow_count);
    rsp.is_empty    = (shadow_count == 0);
    return rsp;
  endfunction

  function automatic dir_row_t dir_row(cmd_t c, int idx, logic [DW-1:0] v, bit typed,
                                       logic [DW-1:0] vout = '0, status_t st = STAT_OK,
                                       int cnt = 0);
    dir_row_t row;
    row.op.cmd           = c;
    row.op.index         = IW'(idx);
    row.op.value         = v;
    row.typed            = typed;
    row.rsp.value_out    = vout;
    row.rsp.status       = st;
    row.rsp.entry_count  = CW'(cnt);
    row.rsp.is_empty     = (cnt == 0);
    return row;
  endfunction

  // drive one transaction at the falling edge, wait for acceptance
  task automatic issue_op(input list_op_t op, input list_rsp_t rsp);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap      = $urandom_range(1, 4);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd   = op.cmd;
    in_index = op.index;
    in_value = op.value;
    do @(posedge clk); while (in_stall);
    pending_rsps.push_back(rsp);
    @(negedge clk);
  endtask

  // result side back-pressure in short bursts
  initial begin
    int burst;
    burst     = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        burst--;
        out_stall = 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        burst     = $urandom_range(0, 3);
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // check every accepted result against the oldest expectation
  always @(posedge clk) begin
    list_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsps.size() == 0) begin
        $error("unexpected result transaction: value_out %h status %0d count %0d",
               out_value_out, out_status, out_entry_count);
        mismatches++;
      end else begin
        want = pending_rsps.pop_front();
        if (out_value_out !== want.value_out) begin
          $error("value_out: expected %h, got %h", want.value_out, out_value_out);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_entry_count);
          mismatches++;
        end
        if (out_is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, out_is_empty);
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin
    dir_row_t  directed_ops [$];
    list_op_t  op;
    list_rsp_t rsp;
    phase_t    phase;
    int        linger;
    int        roll;
    int        dup_pct;
    int        ticks;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_cmd       = CMD_INSERT;
    in_index     = '0;
    in_value     = '0;
    idle_on      = 1'b1;
    shadow_count = 0;

    // empty list, extremes, duplicates and range errors
    directed_ops.push_back(dir_row(CMD_GET,    0,   32'h0000_0000, 1, 0, STAT_OK,      0));
    directed_ops.push_back(dir_row(CMD_SET,    0,   32'hFFFF_FFFF, 1, 0, STAT_RANGE,   0));
    directed_ops.push_back(dir_row(CMD_REMOVE, 255, 32'h0000_0000, 1, 0, STAT_RANGE,   0));
    directed_ops.push_back(dir_row(CMD_INSERT, 0,   32'h0000_0000, 1, 0, STAT_OK,      1));
    directed_ops.push_back(dir_row(CMD_INSERT, 255, 32'hFFFF_FFFF, 1, 0, STAT_OK,      2));
    directed_ops.push_back(dir_row(CMD_INSERT, 0,   32'h0000_0000, 1, 0, STAT_PRESENT, 2));
    directed_ops.push_back(dir_row(CMD_GET,    1,   32'h0000_0000, 1, 32'hFFFF_FFFF,
                                   STAT_OK, 2));
    directed_ops.push_back(dir_row(CMD_GET,    2,   32'hFFFF_FFFF, 1, 0, STAT_OK,      2));
    directed_ops.push_back(dir_row(CMD_GET,    255, 32'h0000_0000, 1, 0, STAT_OK,      2));
    directed_ops.push_back(dir_row(CMD_SET,    1,   32'hA5A5_A5A5, 1, 0, STAT_OK,      2));
    directed_ops.push_back(dir_row(CMD_SET,    2,   32'h1111_1111, 1, 0, STAT_RANGE,   2));
    directed_ops.push_back(dir_row(CMD_SET,    255, 32'h2222_2222, 1, 0, STAT_RANGE,   2));
    directed_ops.push_back(dir_row(CMD_INSERT, 0,   32'h1234_5678, 0));
    directed_ops.push_back(dir_row(CMD_INSERT, 0,   32'hFFFF_FFFF, 0));
    directed_ops.push_back(dir_row(CMD_INSERT, 0,   32'hA5A5_A5A5, 0));
    directed_ops.push_back(dir_row(CMD_REMOVE, 0,   32'h0000_0000, 0));
    directed_ops.push_back(dir_row(CMD_GET,    0,   32'h0000_0000, 0));
    directed_ops.push_back(dir_row(CMD_REMOVE, 3,   32'h0000_0000, 0));
    directed_ops.push_back(dir_row(CMD_REMOVE, 2,   32'h0000_0000, 0));
    directed_ops.push_back(dir_row(CMD_REMOVE, 0,   32'h0000_0000, 0));
    directed_ops.push_back(dir_row(CMD_REMOVE, 0,   32'h0000_0000, 0));
    directed_ops.push_back(dir_row(CMD_REMOVE, 0,   32'h0000_0000, 1, 0, STAT_RANGE,   0));
    directed_ops.push_back(dir_row(CMD_INSERT, 7,   32'h5A5A_5A5A, 1, 0, STAT_OK,      1));

    // synchronous reset, released at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_ops[i]) begin
      rsp = apply_list_op(directed_ops[i].op);
      issue_op(directed_ops[i].op, directed_ops[i].typed ? directed_ops[i].rsp : rsp);
    end

    // random part: fill to capacity, drain, then mixed traffic
    phase  = PH_GROW;
    linger = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n >= RAND_ITEMS - QUIET_ITEMS) idle_on = 1'b0;

      // phase tracking, lingering a few items at full and at empty
      if (phase == PH_GROW && shadow_count == DEPTH) begin
        linger++;
        if (linger > 12) begin
          phase  = PH_SHRINK;
          linger = 0;
        end
      end else if (phase == PH_SHRINK && shadow_count == 0) begin
        linger++;
        if (linger > 5) phase = PH_MIX;
      end

      // command mix per phase
      roll = $urandom_range(0, 99);
      case (phase)
        PH_GROW: begin
          op.cmd  = roll < 80 ? CMD_INSERT : roll < 87 ? CMD_GET :
                    roll < 94 ? CMD_SET : CMD_REMOVE;
          dup_pct = 10;
        end
        PH_SHRINK: begin
          op.cmd  = roll < 80 ? CMD_REMOVE : roll < 87 ? CMD_INSERT :
                    roll < 94 ? CMD_GET : CMD_SET;
          dup_pct = 35;
        end
        default: begin
          op.cmd  = roll < 25 ? CMD_INSERT : roll < 50 ? CMD_GET :
                    roll < 75 ? CMD_SET : CMD_REMOVE;
          dup_pct = 35;
        end
      endcase

      // word: often one already held, sometimes an extreme
      roll = $urandom_range(0, 99);
      if (shadow_count > 0 && roll < dup_pct)
        op.value = shadow_words[$urandom_range(0, shadow_count - 1)];
      else if (roll < dup_pct + 5)
        op.value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      else
        op.value = $urandom;

      // position: mostly inside the list, otherwise anywhere
      if (shadow_count > 0 && $urandom_range(0, 4) != 0)
        op.index = IW'($urandom_range(0, shadow_count - 1));
      else
        op.index = IW'($urandom_range(0, 255));

      rsp = apply_list_op(op);
      issue_op(op, rsp);
    end
    in_valid = 1'b0;

    // wait for the last results, then a little longer for strays
    while (pending_rsps.size() > 0) @(posedge clk);
    ticks = 0;
    while (ticks < DRAIN_TICKS) begin
      @(posedge clk);
      ticks++;
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
